### design/nbbs_pkg.sv
// shared types, codes and constants of the naive bayes bit scorer
package nbbs_pkg;

    localparam int KEY_W           = 44;
    localparam int SUM_W           = 32;
    localparam int HIT_W           = 16;
    localparam int DEF_TABLE       = 1024;
    localparam int DEF_CLASSES     = 8;
    localparam int DEF_WEIGHT_BITS = 24;

    localparam logic [1:0] REG_CUTOFF = 2'd0;
    localparam logic [1:0] REG_LOWER  = 2'd1;
    localparam logic [1:0] REG_CLASS  = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_SCORE  = 2'd2,
        OP_FINISH = 2'd3
    } nbbs_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ADD,
        ST_NEXT,
        ST_FIN_CMP,
        ST_FIN_OUT
    } nbbs_state_t;

    typedef struct packed {
        logic       clr_all;
        logic       add_en;
        logic       cmp_init;
        logic       cmp_en;
        logic       hit_inc;
        logic [2:0] rd_cls;
    } nbbs_sum_ctl_t;

endpackage

### design/nbbs_key_mem.sv
// key store: one write port, one registered read port
module nbbs_key_mem #(
    parameter int TABLE_ENTRIES = nbbs_pkg::DEF_TABLE,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [IDX_W-1:0]           waddr,
    input  logic [nbbs_pkg::KEY_W-1:0] wdata,
    input  logic [IDX_W-1:0]           raddr,
    output logic [nbbs_pkg::KEY_W-1:0] rdata
);

    logic [nbbs_pkg::KEY_W-1:0] mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/nbbs_wt_mem.sv
// weight store, one word per entry and class, registered read
module nbbs_wt_mem #(
    parameter int DEPTH       = 8192,
    parameter int ADDR_W      = $clog2(DEPTH),
    parameter int WEIGHT_BITS = nbbs_pkg::DEF_WEIGHT_BITS
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [ADDR_W-1:0]      waddr,
    input  logic [WEIGHT_BITS-1:0] wdata,
    input  logic [ADDR_W-1:0]      raddr,
    output logic [WEIGHT_BITS-1:0] rdata
);

    logic [WEIGHT_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/nbbs_sum_unit.sv
// class sums with the shared saturating adder and compare, plus hit counter
module nbbs_sum_unit #(
    parameter int MAX_CLASSES = nbbs_pkg::DEF_CLASSES,
    parameter int WEIGHT_BITS = nbbs_pkg::DEF_WEIGHT_BITS,
    parameter int CLS_W       = $clog2(MAX_CLASSES)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  nbbs_pkg::nbbs_sum_ctl_t    ctl,
    input  logic [WEIGHT_BITS-1:0]     weight,
    output logic [nbbs_pkg::SUM_W-1:0] sums [MAX_CLASSES],
    output logic [2:0]                 best_cls,
    output logic [nbbs_pkg::HIT_W-1:0] hits
);

    logic [nbbs_pkg::SUM_W-1:0] sum_reg [MAX_CLASSES];
    logic [nbbs_pkg::SUM_W-1:0] best_val_reg;
    logic [CLS_W-1:0]           best_reg;
    logic [nbbs_pkg::HIT_W-1:0] hits_reg;
    logic [CLS_W-1:0]           sel;
    logic [nbbs_pkg::SUM_W-1:0] cur;
    logic [nbbs_pkg::SUM_W:0]   wide;
    logic [nbbs_pkg::SUM_W-1:0] sat;
    logic                       gt;

    assign sel = ctl.rd_cls[CLS_W-1:0];
    assign cur = sum_reg[sel];
    assign wide = {cur[nbbs_pkg::SUM_W-1], cur}
                + {{(nbbs_pkg::SUM_W+1-WEIGHT_BITS){weight[WEIGHT_BITS-1]}}, weight};

    always_comb
    begin
        if (wide[nbbs_pkg::SUM_W] != wide[nbbs_pkg::SUM_W-1])
        begin
            // saturate towards the sign of the true result
            sat = {wide[nbbs_pkg::SUM_W], {(nbbs_pkg::SUM_W-1){~wide[nbbs_pkg::SUM_W]}}};
        end
        else
        begin
            sat = wide[nbbs_pkg::SUM_W-1:0];
        end
    end

    assign gt = $signed(cur) > $signed(best_val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                sum_reg[i] <= '0;
            end
            hits_reg <= '0;
        end
        else if (ctl.clr_all)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                sum_reg[i] <= '0;
            end
            hits_reg <= '0;
        end
        else
        begin
            if (ctl.add_en)
            begin
                sum_reg[sel] <= sat;
            end
            if (ctl.hit_inc && (hits_reg != {nbbs_pkg::HIT_W{1'b1}}))
            begin
                hits_reg <= hits_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmp_init)
        begin
            best_val_reg <= sum_reg[0];
            best_reg     <= '0;
        end
        else if (ctl.cmp_en && gt)
        begin
            best_val_reg <= cur;
            best_reg     <= sel;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_CLASSES; i++)
        begin
            sums[i] = sum_reg[i];
        end
    end

    assign best_cls = 3'(best_reg);
    assign hits     = hits_reg;

    a_add_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.add_en && ctl.cmp_en))
        else $error("add and compare in the same cycle");
    a_clr_hits: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr_all |=> hits_reg == '0)
        else $error("hit count not cleared");
    a_hit_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (hits_reg == {nbbs_pkg::HIT_W{1'b1}}) && !ctl.clr_all |=> hits_reg == $past(hits_reg))
        else $error("hit count wrapped");

endmodule

### design/naive_bayes_bit_scorer.sv
// top level of the naive bayes bit scorer: sequencer, key search and result registers
//
// Items enter on start when busy is low; operation picks clear, load, score or finish.
// Clear takes effect at once and leaves busy low. Configuration is written through
// cfg_we / cfg_index / cfg_data; the user must write it only while busy is low (the
// block does not enforce this), and it then applies to the next item. A load or score
// item searches the stored keys one per cycle through the key memory read port. A
// score item repeats the search for each count step from the clamped count down to
// 1 when include_lower is set, and each hit adds the class weights one class per
// cycle through the single adder.
// A finish item yields one result: the outputs hold it and done is high for exactly
// one cycle, after which class sums and hit count are zero. The receiver cannot stall.
// Reset empties the key table, clears sums, hit count and overflow flag, and loads
// count_cutoff 1, include_lower 1, class_count 2. No clearing pass follows reset.
module naive_bayes_bit_scorer #(
    parameter int TABLE_ENTRIES = nbbs_pkg::DEF_TABLE,
    parameter int MAX_CLASSES   = nbbs_pkg::DEF_CLASSES,
    parameter int WEIGHT_BITS   = nbbs_pkg::DEF_WEIGHT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [3:0]  fp_index,
    input  logic [31:0] bit_number,
    input  logic [7:0]  bit_cnt,
    input  logic [2:0]  class_index,
    input  logic signed [23:0] weight_value,
    output logic        done,
    output logic [2:0]  predicted_class,
    output logic signed [31:0] score_0,
    output logic signed [31:0] score_1,
    output logic signed [31:0] score_2,
    output logic signed [31:0] score_3,
    output logic signed [31:0] score_4,
    output logic signed [31:0] score_5,
    output logic signed [31:0] score_6,
    output logic signed [31:0] score_7,
    output logic [15:0] hit_count,
    output logic        table_overflow
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int USED_W = IDX_W + 1;
    localparam int CLS_W  = $clog2(MAX_CLASSES);
    localparam int WA_W   = IDX_W + CLS_W;
    localparam logic signed [32:0] WMAX = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] WMIN = -(33'sd1 <<< (WEIGHT_BITS - 1));

    nbbs_pkg::nbbs_state_t state_reg, state_next;

    logic [7:0]  cutoff_reg;
    logic        lower_reg;
    logic [3:0]  ccount_reg;

    nbbs_pkg::nbbs_op_t op_reg, op_next;
    logic [nbbs_pkg::KEY_W-1:0] key_reg, key_next;
    logic [2:0]  cls_reg, cls_next;
    logic [WEIGHT_BITS-1:0] wt_reg, wt_next;

    logic [USED_W-1:0] used_reg, used_next;
    logic              ovf_reg, ovf_next;
    logic [USED_W-1:0] idx_reg, idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]  ent_reg, ent_next;
    logic [3:0]        k_reg, k_next;
    logic              kp_vld_reg, kp_vld_next;
    logic [3:0]        kp_cls_reg, kp_cls_next;
    logic              done_reg, done_next;

    logic        accept;
    logic [7:0]  cnt_eff;
    logic [3:0]  n_cls;
    logic        cls_ok;
    logic        issue;
    logic        match;
    logic        search_end;
    logic        k_issue;
    logic [32:0] w_ext;
    logic [WEIGHT_BITS-1:0] w_sat;

    logic        key_we;
    logic [IDX_W-1:0] key_waddr;
    logic [nbbs_pkg::KEY_W-1:0] key_rd;
    logic        wt_we;
    logic [WA_W-1:0] wt_waddr;
    logic [WA_W-1:0] wt_raddr;
    logic [WEIGHT_BITS-1:0] wt_rd;

    nbbs_pkg::nbbs_sum_ctl_t ctl;
    logic [nbbs_pkg::SUM_W-1:0] sums [MAX_CLASSES];
    logic [2:0]  best_cls;
    logic [nbbs_pkg::HIT_W-1:0] hits;

    logic [2:0]  pred_reg;
    logic [nbbs_pkg::SUM_W-1:0] score_reg [8];
    logic [15:0] hitc_reg;
    logic        tovf_reg;

    assign accept  = start && !busy;
    assign busy    = state_reg != nbbs_pkg::ST_IDLE;
    assign cnt_eff = (bit_cnt > cutoff_reg) ? cutoff_reg : bit_cnt;
    assign cls_ok  = {1'b0, class_index} < 4'(MAX_CLASSES);

    always_comb
    begin
        if (ccount_reg == 4'd0)
        begin
            n_cls = 4'd1;
        end
        else if (ccount_reg > 4'(MAX_CLASSES))
        begin
            n_cls = 4'(MAX_CLASSES);
        end
        else
        begin
            n_cls = ccount_reg;
        end
    end

    // clamp the 24-bit weight to the stored width
    assign w_ext = {{9{weight_value[23]}}, weight_value};
    always_comb
    begin
        if ($signed(w_ext) > WMAX)
        begin
            w_sat = WMAX[WEIGHT_BITS-1:0];
        end
        else if ($signed(w_ext) < WMIN)
        begin
            w_sat = WMIN[WEIGHT_BITS-1:0];
        end
        else
        begin
            w_sat = w_ext[WEIGHT_BITS-1:0];
        end
    end

    // search pipeline: address issued one cycle, key compared the next
    assign issue      = idx_reg < used_reg;
    assign match      = chk_vld_reg && (key_rd == key_reg);
    assign search_end = !issue && !chk_vld_reg;
    assign k_issue    = k_reg < n_cls;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= 8'd1;
            lower_reg  <= 1'b1;
            ccount_reg <= 4'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nbbs_pkg::REG_CUTOFF: cutoff_reg <= cfg_data;
                nbbs_pkg::REG_LOWER:  lower_reg  <= cfg_data[0];
                nbbs_pkg::REG_CLASS:  ccount_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nbbs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (nbbs_pkg::nbbs_op_t'(operation))
                        nbbs_pkg::OP_LOAD:
                            if (cls_ok) state_next = nbbs_pkg::ST_SEARCH;
                        nbbs_pkg::OP_SCORE:
                            if (cnt_eff != 8'd0) state_next = nbbs_pkg::ST_SEARCH;
                        nbbs_pkg::OP_FINISH:
                            state_next = (n_cls > 4'd1) ? nbbs_pkg::ST_FIN_CMP
                                                        : nbbs_pkg::ST_FIN_OUT;
                        default: ;
                    endcase
                end
            end
            nbbs_pkg::ST_SEARCH:
            begin
                if (match)
                begin
                    state_next = (op_reg == nbbs_pkg::OP_SCORE) ? nbbs_pkg::ST_ADD
                                                                : nbbs_pkg::ST_IDLE;
                end
                else if (search_end)
                begin
                    state_next = (op_reg == nbbs_pkg::OP_SCORE) ? nbbs_pkg::ST_NEXT
                                                                : nbbs_pkg::ST_IDLE;
                end
            end
            nbbs_pkg::ST_ADD:
            begin
                if (!k_issue && !kp_vld_reg)
                begin
                    state_next = nbbs_pkg::ST_NEXT;
                end
            end
            nbbs_pkg::ST_NEXT:
            begin
                state_next = (lower_reg && key_reg[7:0] > 8'd1) ? nbbs_pkg::ST_SEARCH
                                                                : nbbs_pkg::ST_IDLE;
            end
            nbbs_pkg::ST_FIN_CMP:
            begin
                if (k_reg + 4'd1 >= n_cls)
                begin
                    state_next = nbbs_pkg::ST_FIN_OUT;
                end
            end
            nbbs_pkg::ST_FIN_OUT:
            begin
                state_next = nbbs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nbbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next      = op_reg;
        key_next     = key_reg;
        cls_next     = cls_reg;
        wt_next      = wt_reg;
        used_next    = used_reg;
        ovf_next     = ovf_reg;
        idx_next     = idx_reg;
        chk_vld_next = chk_vld_reg;
        chk_idx_next = chk_idx_reg;
        ent_next     = ent_reg;
        k_next       = k_reg;
        kp_vld_next  = 1'b0;
        kp_cls_next  = kp_cls_reg;
        done_next    = 1'b0;
        key_we       = 1'b0;
        key_waddr    = used_reg[IDX_W-1:0];
        wt_we        = 1'b0;
        wt_waddr     = {chk_idx_reg, cls_reg[CLS_W-1:0]};
        wt_raddr     = {ent_reg, k_reg[CLS_W-1:0]};
        ctl          = '0;
        ctl.rd_cls   = 3'(kp_cls_reg);
        case (state_reg)
            nbbs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = nbbs_pkg::nbbs_op_t'(operation);
                    key_next     = {fp_index, bit_number,
                                    (operation == nbbs_pkg::OP_SCORE) ? cnt_eff : bit_cnt};
                    cls_next     = class_index;
                    wt_next      = w_sat;
                    idx_next     = '0;
                    chk_vld_next = 1'b0;
                    k_next       = 4'd1;
                    case (nbbs_pkg::nbbs_op_t'(operation))
                        nbbs_pkg::OP_CLEAR:
                        begin
                            used_next = '0;
                            ovf_next  = 1'b0;
                        end
                        nbbs_pkg::OP_FINISH:
                            ctl.cmp_init = 1'b1;
                        default: ;
                    endcase
                end
            end
            nbbs_pkg::ST_SEARCH:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                chk_vld_next = issue && !match;
                chk_idx_next = idx_reg[IDX_W-1:0];
                if (match)
                begin
                    ent_next = chk_idx_reg;
                    k_next   = '0;
                    if (op_reg == nbbs_pkg::OP_LOAD)
                    begin
                        wt_we = 1'b1;
                    end
                end
                else if (search_end && op_reg == nbbs_pkg::OP_LOAD)
                begin
                    if (used_reg == USED_W'(TABLE_ENTRIES))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        key_we    = 1'b1;
                        wt_we     = 1'b1;
                        wt_waddr  = {used_reg[IDX_W-1:0], cls_reg[CLS_W-1:0]};
                        used_next = used_reg + 1'b1;
                    end
                end
            end
            nbbs_pkg::ST_ADD:
            begin
                if (k_issue)
                begin
                    k_next = k_reg + 4'd1;
                end
                kp_vld_next = k_issue;
                kp_cls_next = k_reg;
                ctl.add_en  = kp_vld_reg;
                ctl.hit_inc = !k_issue && !kp_vld_reg;
            end
            nbbs_pkg::ST_NEXT:
            begin
                key_next[7:0] = key_reg[7:0] - 8'd1;
                idx_next      = '0;
                chk_vld_next  = 1'b0;
            end
            nbbs_pkg::ST_FIN_CMP:
            begin
                ctl.cmp_en = 1'b1;
                ctl.rd_cls = 3'(k_reg);
                k_next     = k_reg + 4'd1;
            end
            nbbs_pkg::ST_FIN_OUT:
            begin
                ctl.clr_all = 1'b1;
                done_next   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nbbs_pkg::ST_IDLE;
            used_reg    <= '0;
            ovf_reg     <= 1'b0;
            chk_vld_reg <= 1'b0;
            kp_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            ovf_reg     <= ovf_next;
            chk_vld_reg <= chk_vld_next;
            kp_vld_reg  <= kp_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        cls_reg     <= cls_next;
        wt_reg      <= wt_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        ent_reg     <= ent_next;
        k_reg       <= k_next;
        kp_cls_reg  <= kp_cls_next;
        if (state_reg == nbbs_pkg::ST_FIN_OUT)
        begin
            pred_reg <= best_cls;
            hitc_reg <= hits;
            tovf_reg <= ovf_reg;
            for (int i = 0; i < 8; i++)
            begin
                score_reg[i] <= (i < MAX_CLASSES) ? sums[i] : '0;
            end
        end
    end

    nbbs_key_mem #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_key_mem (
        .clk  (clk),
        .we   (key_we),
        .waddr(key_waddr),
        .wdata(key_reg),
        .raddr(idx_reg[IDX_W-1:0]),
        .rdata(key_rd)
    );

    nbbs_wt_mem #(
        .DEPTH      (TABLE_ENTRIES << CLS_W),
        .ADDR_W     (WA_W),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_wt_mem (
        .clk  (clk),
        .we   (wt_we),
        .waddr(wt_waddr),
        .wdata(wt_reg),
        .raddr(wt_raddr),
        .rdata(wt_rd)
    );

    nbbs_sum_unit #(
        .MAX_CLASSES(MAX_CLASSES),
        .WEIGHT_BITS(WEIGHT_BITS),
        .CLS_W      (CLS_W)
    ) u_sum (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .weight  (wt_rd),
        .sums    (sums),
        .best_cls(best_cls),
        .hits    (hits)
    );

    assign done            = done_reg;
    assign predicted_class = pred_reg;
    assign score_0         = score_reg[0];
    assign score_1         = score_reg[1];
    assign score_2         = score_reg[2];
    assign score_3         = score_reg[3];
    assign score_4         = score_reg[4];
    assign score_5         = score_reg[5];
    assign score_6         = score_reg[6];
    assign score_7         = score_reg[7];
    assign hit_count       = hitc_reg;
    assign table_overflow  = tovf_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == nbbs_pkg::ST_FIN_OUT))
        else $error("result strobe without finish");
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && operation == nbbs_pkg::OP_FINISH |=> busy)
        else $error("finish item did not start");

endmodule
